// ===== hdl/mivo_pkg.sv =====
// Shared types, constants and helpers for the minimum image vector block.
package mivo_pkg;

	localparam int NAXES     = 3;
	localparam int NSTG      = 7;
	localparam int COORD_W   = 32;
	localparam int LEN_W     = 31;
	localparam int INV_W     = 32;
	localparam int DIST_W    = 62;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = COORD_W + INV_W;
	localparam int CNT_W     = 17;
	localparam int SHIFT_W   = CNT_W + LEN_W;
	localparam int VEC_W     = 50;
	localparam int IMG_W     = VEC_W + 1;
	localparam int MAG_W     = 31;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [LEN_W-1:0]          len_t;
	typedef logic [INV_W-1:0]          inv_t;
	typedef logic [DIST_W-1:0]         dist_t;

	localparam len_t   LEN_RST  = len_t'(65536);
	localparam inv_t   INV_RST  = {INV_W{1'b1}};
	localparam dist_t  DSQ_MAX  = {DIST_W{1'b1}};
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_X = 3'd0,
		REG_BOX_Y = 3'd1,
		REG_BOX_Z = 3'd2,
		REG_INV_X = 3'd3,
		REG_INV_Y = 3'd4,
		REG_INV_Z = 3'd5
	} cfg_reg_t;

	// Load enables, one per pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_en_t;

	function automatic coord_t sat32(input logic signed [IMG_W-1:0] x);
		coord_t r;
		if (x > IMG_W'(signed'(COORD_MAX))) begin
			r = COORD_MAX;
		end else if (x < IMG_W'(signed'(COORD_MIN))) begin
			r = COORD_MIN;
		end else begin
			r = x[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/mivo_ctrl.sv =====
// Valid bits and stage load enables for the pipeline.
module mivo_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mivo_pkg::stage_en_t  en
);

	logic [mivo_pkg::NSTG-1:0] vld_q;
	logic [mivo_pkg::NSTG:0]   rdy;

	// A stage may load when it is empty or its contents move on
	always_comb begin
		rdy[mivo_pkg::NSTG] = !out_stall;
		for (int k = mivo_pkg::NSTG - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < mivo_pkg::NSTG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[mivo_pkg::NSTG-1];

	assign en.s1 = rdy[0];
	assign en.s2 = rdy[1];
	assign en.s3 = rdy[2];
	assign en.s4 = rdy[3];
	assign en.s5 = rdy[4];
	assign en.s6 = rdy[5];
	assign en.s7 = rdy[6];

endmodule

// ===== hdl/mivo_axis.sv =====
// One axis datapath: difference, image count, wrap, saturation and square.
module mivo_axis (
	input  logic                         clk,
	input  mivo_pkg::stage_en_t          en,
	input  mivo_pkg::coord_t             a,
	input  mivo_pkg::coord_t             b,
	input  mivo_pkg::len_t               len,
	input  mivo_pkg::inv_t               inv,
	output mivo_pkg::coord_t             vec,
	output mivo_pkg::coord_t             image,
	output logic [mivo_pkg::DIST_W-1:0]  sq,
	output logic                         over
);

	// stage 1: signed difference and its magnitude
	logic signed [mivo_pkg::DIFF_W-1:0] diff_ba, diff_ab;
	logic signed [mivo_pkg::DIFF_W-1:0] d_s1, d_s2, d_s3;
	logic [mivo_pkg::COORD_W-1:0]       mag_s1;
	logic                               neg_s1, neg_s2, neg_s3;
	mivo_pkg::coord_t                   b_s1, b_s2, b_s3, b_s4;

	assign diff_ba = $signed({b[mivo_pkg::COORD_W-1], b}) - $signed({a[mivo_pkg::COORD_W-1], a});
	assign diff_ab = $signed({a[mivo_pkg::COORD_W-1], a}) - $signed({b[mivo_pkg::COORD_W-1], b});

	always_ff @(posedge clk) begin
		if (en.s1) begin
			d_s1   <= diff_ba;
			neg_s1 <= diff_ba[mivo_pkg::DIFF_W-1];
			mag_s1 <= diff_ba[mivo_pkg::DIFF_W-1] ? diff_ab[mivo_pkg::COORD_W-1:0]
			                                      : diff_ba[mivo_pkg::COORD_W-1:0];
			b_s1   <= b;
		end
	end

	// stage 2: |d| times reciprocal, Q16.48
	logic [mivo_pkg::PROD_W-1:0] prod, p_s2;

	assign prod = mag_s1 * inv;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_s2   <= prod;
			d_s2   <= d_s1;
			neg_s2 <= neg_s1;
			b_s2   <= b_s1;
		end
	end

	// stage 3: round half up on magnitude, then count times box length
	logic [mivo_pkg::CNT_W:0]     cnt_rnd;
	logic [mivo_pkg::CNT_W-1:0]   cnt;
	logic [mivo_pkg::SHIFT_W-1:0] shift, shift_s3;

	assign cnt_rnd = (mivo_pkg::CNT_W+1)'(p_s2[mivo_pkg::PROD_W-1:mivo_pkg::PROD_W-mivo_pkg::CNT_W])
	               + (mivo_pkg::CNT_W+1)'(1);
	assign cnt     = cnt_rnd[mivo_pkg::CNT_W:1];
	assign shift   = cnt * len;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			shift_s3 <= shift;
			d_s3     <= d_s2;
			neg_s3   <= neg_s2;
			b_s3     <= b_s2;
		end
	end

	// stage 4: move the difference toward zero by whole boxes
	logic signed [mivo_pkg::VEC_W-1:0] d_ext, sh_ext, v_s4;

	assign d_ext  = {{(mivo_pkg::VEC_W-mivo_pkg::DIFF_W){d_s3[mivo_pkg::DIFF_W-1]}}, d_s3};
	assign sh_ext = {{(mivo_pkg::VEC_W-mivo_pkg::SHIFT_W){1'b0}}, shift_s3};

	always_ff @(posedge clk) begin
		if (en.s4) begin
			v_s4 <= neg_s3 ? d_ext + sh_ext : d_ext - sh_ext;
			b_s4 <= b_s3;
		end
	end

	// stage 5: saturate vector and image, take magnitude for the square
	logic signed [mivo_pkg::IMG_W-1:0] v_wide, b_wide, img_wide;
	logic signed [mivo_pkg::VEC_W-1:0] v_abs;
	logic                              v_big;
	mivo_pkg::coord_t                  vec_s5, img_s5, vec_s6, img_s6;
	logic [mivo_pkg::MAG_W-1:0]        m_s5;
	logic                              over_s5, over_s6;
	logic [mivo_pkg::DIST_W-1:0]       sq_s6;

	assign v_wide   = {v_s4[mivo_pkg::VEC_W-1], v_s4};
	assign b_wide   = {{(mivo_pkg::IMG_W-mivo_pkg::COORD_W){b_s4[mivo_pkg::COORD_W-1]}}, b_s4};
	assign img_wide = b_wide - v_wide;
	assign v_abs    = v_s4[mivo_pkg::VEC_W-1] ? -v_s4 : v_s4;
	assign v_big    = (v_s4 >= $signed(mivo_pkg::VEC_W'(64'sd2147483648)))
	               || (v_s4 <= $signed(mivo_pkg::VEC_W'(-64'sd2147483648)));

	always_ff @(posedge clk) begin
		if (en.s5) begin
			vec_s5  <= mivo_pkg::sat32(v_wide);
			img_s5  <= mivo_pkg::sat32(img_wide);
			m_s5    <= v_abs[mivo_pkg::MAG_W-1:0];
			over_s5 <= v_big;
		end
	end

	// stage 6: square of the component
	always_ff @(posedge clk) begin
		if (en.s6) begin
			sq_s6   <= m_s5 * m_s5;
			vec_s6  <= vec_s5;
			img_s6  <= img_s5;
			over_s6 <= over_s5;
		end
	end

	assign vec   = vec_s6;
	assign image = img_s6;
	assign sq    = sq_s6;
	assign over  = over_s6;

endmodule

// ===== hdl/mivo_dist.sv =====
// Sum of the three squares with saturation to the Q30.32 range.
module mivo_dist (
	input  logic [mivo_pkg::DIST_W-1:0] sq [mivo_pkg::NAXES],
	input  logic [mivo_pkg::NAXES-1:0]  over,
	output mivo_pkg::dist_t             dsq
);

	logic [mivo_pkg::DIST_W+1:0] sum;

	assign sum = (mivo_pkg::DIST_W+2)'(sq[0]) + (mivo_pkg::DIST_W+2)'(sq[1])
	           + (mivo_pkg::DIST_W+2)'(sq[2]);

	// clamp when any axis is too long to square or the sum overflows
	assign dsq = ((|over) || (sum > (mivo_pkg::DIST_W+2)'(mivo_pkg::DSQ_MAX)))
	           ? mivo_pkg::DSQ_MAX : sum[mivo_pkg::DIST_W-1:0];

endmodule

// ===== hdl/minimum_image_vector_orthorhombic.sv =====
// Top level: minimum image vector, image point and squared distance for a periodic box.
//
//   channel   direction  handshake                 payload
//   cfg       in         cfg_we                    cfg_idx, cfg_wdata
//   pair      in         pair_valid / pair_stall   first_x..z, second_x..z
//   res       out        res_valid / res_stall     vec_x..z, image_x..z, dist_sq
//
// One request per cycle unless a held result backs up every stage. Two chained
// multipliers per axis (|d| * reciprocal, then count * length), the square and the
// final sum each sit behind their own register.
// Reset clears the stage valid bits and loads the box registers with 1.0.
// A stalled result freezes only the full stages; empty stages keep filling.
module minimum_image_vector_orthorhombic (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mivo_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [mivo_pkg::CFG_DAT_W-1:0]       cfg_wdata,
	input  logic                                 pair_valid,
	output logic                                 pair_stall,
	input  logic signed [mivo_pkg::COORD_W-1:0]  first_x,
	input  logic signed [mivo_pkg::COORD_W-1:0]  first_y,
	input  logic signed [mivo_pkg::COORD_W-1:0]  first_z,
	input  logic signed [mivo_pkg::COORD_W-1:0]  second_x,
	input  logic signed [mivo_pkg::COORD_W-1:0]  second_y,
	input  logic signed [mivo_pkg::COORD_W-1:0]  second_z,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic signed [mivo_pkg::COORD_W-1:0]  vec_x,
	output logic signed [mivo_pkg::COORD_W-1:0]  vec_y,
	output logic signed [mivo_pkg::COORD_W-1:0]  vec_z,
	output logic signed [mivo_pkg::COORD_W-1:0]  image_x,
	output logic signed [mivo_pkg::COORD_W-1:0]  image_y,
	output logic signed [mivo_pkg::COORD_W-1:0]  image_z,
	output logic [mivo_pkg::DIST_W-1:0]          dist_sq
);

	mivo_pkg::len_t    box_len_q [mivo_pkg::NAXES];
	mivo_pkg::inv_t    inv_len_q [mivo_pkg::NAXES];
	mivo_pkg::stage_en_t en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mivo_pkg::NAXES; i++) begin
				box_len_q[i] <= mivo_pkg::LEN_RST;
				inv_len_q[i] <= mivo_pkg::INV_RST;
			end
		end else if (cfg_we) begin
			case (mivo_pkg::cfg_reg_t'(cfg_idx))
				mivo_pkg::REG_BOX_X: box_len_q[0] <= cfg_wdata[mivo_pkg::LEN_W-1:0];
				mivo_pkg::REG_BOX_Y: box_len_q[1] <= cfg_wdata[mivo_pkg::LEN_W-1:0];
				mivo_pkg::REG_BOX_Z: box_len_q[2] <= cfg_wdata[mivo_pkg::LEN_W-1:0];
				mivo_pkg::REG_INV_X: inv_len_q[0] <= cfg_wdata[mivo_pkg::INV_W-1:0];
				mivo_pkg::REG_INV_Y: inv_len_q[1] <= cfg_wdata[mivo_pkg::INV_W-1:0];
				mivo_pkg::REG_INV_Z: inv_len_q[2] <= cfg_wdata[mivo_pkg::INV_W-1:0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	mivo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pair_valid),
		.in_stall  (pair_stall),
		.out_valid (res_valid),
		.out_stall (res_stall),
		.en        (en)
	);

	mivo_pkg::coord_t            a_in [mivo_pkg::NAXES];
	mivo_pkg::coord_t            b_in [mivo_pkg::NAXES];
	mivo_pkg::coord_t            vec_ax [mivo_pkg::NAXES];
	mivo_pkg::coord_t            img_ax [mivo_pkg::NAXES];
	logic [mivo_pkg::DIST_W-1:0] sq_ax [mivo_pkg::NAXES];
	logic [mivo_pkg::NAXES-1:0]  over_ax;
	mivo_pkg::dist_t             dsq_sum;

	assign a_in[0] = first_x;
	assign a_in[1] = first_y;
	assign a_in[2] = first_z;
	assign b_in[0] = second_x;
	assign b_in[1] = second_y;
	assign b_in[2] = second_z;

	for (genvar g = 0; g < mivo_pkg::NAXES; g++) begin : g_axis
		mivo_axis u_axis (
			.clk   (clk),
			.en    (en),
			.a     (a_in[g]),
			.b     (b_in[g]),
			.len   (box_len_q[g]),
			.inv   (inv_len_q[g]),
			.vec   (vec_ax[g]),
			.image (img_ax[g]),
			.sq    (sq_ax[g]),
			.over  (over_ax[g])
		);
	end

	mivo_dist u_dist (
		.sq   (sq_ax),
		.over (over_ax),
		.dsq  (dsq_sum)
	);

	// stage 7: output register
	mivo_pkg::coord_t vec_s7 [mivo_pkg::NAXES];
	mivo_pkg::coord_t img_s7 [mivo_pkg::NAXES];
	mivo_pkg::dist_t  dist_s7;

	always_ff @(posedge clk) begin
		if (en.s7) begin
			for (int i = 0; i < mivo_pkg::NAXES; i++) begin
				vec_s7[i] <= vec_ax[i];
				img_s7[i] <= img_ax[i];
			end
			dist_s7 <= dsq_sum;
		end
	end

	assign vec_x   = vec_s7[0];
	assign vec_y   = vec_s7[1];
	assign vec_z   = vec_s7[2];
	assign image_x = img_s7[0];
	assign image_y = img_s7[1];
	assign image_z = img_s7[2];
	assign dist_sq = dist_s7;

	// requests back up only when every stage is full behind a held result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> (res_valid && res_stall))
		else $error("request stalled while the pipeline has room");

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && vec_x == '0 && vec_y == '0 && vec_z == '0) |-> (dist_sq == '0))
		else $error("zero vector with nonzero distance");

	a_neg_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (vec_x == mivo_pkg::COORD_MIN || vec_y == mivo_pkg::COORD_MIN
		               || vec_z == mivo_pkg::COORD_MIN)) |-> (dist_sq == mivo_pkg::DSQ_MAX))
		else $error("saturated component without saturated distance");

endmodule

// ===== bench/mivo_checker.sv =====
// Pair/result monitor: predicts the minimum image result of each pair request and compares.
`timescale 1ns / 100ps

module mivo_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mivo_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [mivo_pkg::CFG_DAT_W-1:0] cfg_wdata,
	input  logic                           pair_valid,
	input  logic                           pair_stall,
	input  mivo_pkg::coord_t               first_x,
	input  mivo_pkg::coord_t               first_y,
	input  mivo_pkg::coord_t               first_z,
	input  mivo_pkg::coord_t               second_x,
	input  mivo_pkg::coord_t               second_y,
	input  mivo_pkg::coord_t               second_z,
	input  logic                           res_valid,
	input  logic                           res_stall,
	input  mivo_pkg::coord_t               vec_x,
	input  mivo_pkg::coord_t               vec_y,
	input  mivo_pkg::coord_t               vec_z,
	input  mivo_pkg::coord_t               image_x,
	input  mivo_pkg::coord_t               image_y,
	input  mivo_pkg::coord_t               image_z,
	input  mivo_pkg::dist_t                dist_sq,
	output int                             errors,
	output int                             outstanding
);

	typedef struct packed {
		mivo_pkg::coord_t vec_x;
		mivo_pkg::coord_t vec_y;
		mivo_pkg::coord_t vec_z;
		mivo_pkg::coord_t image_x;
		mivo_pkg::coord_t image_y;
		mivo_pkg::coord_t image_z;
		mivo_pkg::dist_t  dist_sq;
	} image_result_t;

	mivo_pkg::len_t box_len[mivo_pkg::NAXES];
	mivo_pkg::inv_t inv_len[mivo_pkg::NAXES];
	image_result_t  pending_images[$];
	int             fail_tally = 0;
	int             pending_n = 0;

	assign errors      = fail_tally;
	assign outstanding = pending_n;

	function automatic mivo_pkg::coord_t clamp_q16(input longint x);
		if (x > longint'(mivo_pkg::COORD_MAX)) return mivo_pkg::COORD_MAX;
		if (x < longint'(mivo_pkg::COORD_MIN)) return mivo_pkg::COORD_MIN;
		return mivo_pkg::coord_t'(x);
	endfunction

	function automatic image_result_t predict_image(input mivo_pkg::coord_t fp[mivo_pkg::NAXES],
			input mivo_pkg::coord_t sp[mivo_pkg::NAXES]);
		image_result_t    r;
		mivo_pkg::coord_t vec[mivo_pkg::NAXES];
		mivo_pkg::coord_t img[mivo_pkg::NAXES];
		longint           d;
		longint           v;
		bit [63:0]        mag;
		bit [63:0]        prod;
		bit [63:0]        cnt;
		bit [63:0]        span;
		bit [63:0]        vmag;
		bit [63:0]        acc;
		bit               wide;
		acc  = '0;
		wide = 1'b0;
		for (int i = 0; i < mivo_pkg::NAXES; i++) begin
			d    = longint'(sp[i]) - longint'(fp[i]);
			mag  = (d < 0) ? -d : d;
			prod = mag * {32'd0, inv_len[i]};
			// round half away from zero on the magnitude, sign comes back below
			cnt  = ((prod >> 47) + 64'd1) >> 1;
			span = cnt * {33'd0, box_len[i]};
			v    = (d < 0) ? d + longint'(span) : d - longint'(span);
			vec[i] = clamp_q16(v);
			img[i] = clamp_q16(longint'(sp[i]) - v);
			vmag = (v < 0) ? -v : v;
			if (vmag >= (64'd1 << 31))
				wide = 1'b1;
			else
				acc += vmag * vmag;
		end
		r.vec_x   = vec[0];
		r.vec_y   = vec[1];
		r.vec_z   = vec[2];
		r.image_x = img[0];
		r.image_y = img[1];
		r.image_z = img[2];
		r.dist_sq = (wide || acc > 64'(mivo_pkg::DSQ_MAX)) ? mivo_pkg::DSQ_MAX
			: mivo_pkg::dist_t'(acc);
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mivo_pkg::coord_t fp[mivo_pkg::NAXES];
		mivo_pkg::coord_t sp[mivo_pkg::NAXES];
		image_result_t    want;
		if (!arst_n) begin
			for (int i = 0; i < mivo_pkg::NAXES; i++) begin
				box_len[i] <= mivo_pkg::LEN_RST;
				inv_len[i] <= mivo_pkg::INV_RST;
			end
			pending_images.delete();
			pending_n = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (pending_images.size() == 0) begin
					$error("result with no pending request");
					fail_tally++;
				end else begin
					want = pending_images.pop_front();
					check_field("vec_x", want.vec_x, vec_x);
					check_field("vec_y", want.vec_y, vec_y);
					check_field("vec_z", want.vec_z, vec_z);
					check_field("image_x", want.image_x, image_x);
					check_field("image_y", want.image_y, image_y);
					check_field("image_z", want.image_z, image_z);
					check_field("dist_sq", want.dist_sq, dist_sq);
				end
			end
			if (pair_valid && !pair_stall) begin
				fp = '{first_x, first_y, first_z};
				sp = '{second_x, second_y, second_z};
				pending_images.push_back(predict_image(fp, sp));
			end
			pending_n = pending_images.size();
			if (cfg_we) begin
				// indexes past the last register are dropped
				case (mivo_pkg::cfg_reg_t'(cfg_idx))
					mivo_pkg::REG_BOX_X: box_len[0] <= cfg_wdata[mivo_pkg::LEN_W-1:0];
					mivo_pkg::REG_BOX_Y: box_len[1] <= cfg_wdata[mivo_pkg::LEN_W-1:0];
					mivo_pkg::REG_BOX_Z: box_len[2] <= cfg_wdata[mivo_pkg::LEN_W-1:0];
					mivo_pkg::REG_INV_X: inv_len[0] <= cfg_wdata[mivo_pkg::INV_W-1:0];
					mivo_pkg::REG_INV_Y: inv_len[1] <= cfg_wdata[mivo_pkg::INV_W-1:0];
					mivo_pkg::REG_INV_Z: inv_len[2] <= cfg_wdata[mivo_pkg::INV_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the bench: clock, reset, pair stimulus, box programming and the verdict.
`timescale 1ns / 100ps

module testbench;

	typedef enum int {
		BOX_FITTED,
		BOX_EXTREME,
		BOX_RAW,
		BOX_TINY
	} box_kind_t;

	localparam int SEGMENTS     = 8;
	localparam int SEGMENT_ITEMS = 250;
	localparam int DRAIN_CYCLES = mivo_pkg::NSTG + 4;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [mivo_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [mivo_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;
	logic                           pair_valid = 1'b0;
	logic                           pair_stall;
	mivo_pkg::coord_t               first_x = '0;
	mivo_pkg::coord_t               first_y = '0;
	mivo_pkg::coord_t               first_z = '0;
	mivo_pkg::coord_t               second_x = '0;
	mivo_pkg::coord_t               second_y = '0;
	mivo_pkg::coord_t               second_z = '0;
	logic                           res_valid;
	logic                           res_stall = 1'b0;
	mivo_pkg::coord_t               vec_x;
	mivo_pkg::coord_t               vec_y;
	mivo_pkg::coord_t               vec_z;
	mivo_pkg::coord_t               image_x;
	mivo_pkg::coord_t               image_y;
	mivo_pkg::coord_t               image_z;
	mivo_pkg::dist_t                dist_sq;
	int                             errors;
	int                             outstanding;

	mivo_pkg::len_t lens[mivo_pkg::NAXES] = '{mivo_pkg::LEN_RST, mivo_pkg::LEN_RST,
		mivo_pkg::LEN_RST};
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   pairs_sent = 0;
	int   reg_writes = 0;
	int   idle_send[4] = '{0, 75, 0, 12};
	int   idle_recv[4] = '{0, 0, 75, 12};

	minimum_image_vector_orthorhombic uut (.*);

	mivo_checker u_checker (.*);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		res_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	function automatic mivo_pkg::inv_t recip_of(input logic [31:0] len);
		logic [63:0] q;
		if (len == 0) return '1;
		q = (64'd1 << 48) / len;
		return (q > 64'hFFFF_FFFF) ? '1 : mivo_pkg::inv_t'(q);
	endfunction

	function automatic mivo_pkg::coord_t pick_extreme();
		case ($urandom_range(4))
			0: return mivo_pkg::COORD_MIN;
			1: return mivo_pkg::COORD_MAX;
			2: return '0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	// Leaves cfg_we high; the caller lowers it after the last write.
	task automatic set_reg(input mivo_pkg::cfg_reg_t r, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= r;
		cfg_wdata <= val;
		case (r)
			mivo_pkg::REG_BOX_X: lens[0] = val[mivo_pkg::LEN_W-1:0];
			mivo_pkg::REG_BOX_Y: lens[1] = val[mivo_pkg::LEN_W-1:0];
			mivo_pkg::REG_BOX_Z: lens[2] = val[mivo_pkg::LEN_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic load_box(input box_kind_t kind);
		logic [31:0] bl[mivo_pkg::NAXES];
		logic [31:0] il[mivo_pkg::NAXES];
		for (int i = 0; i < mivo_pkg::NAXES; i++) begin
			case (kind)
				BOX_FITTED: begin
					bl[i] = ($urandom_range(3) == 0) ? $urandom_range(65536, 32'h7FFF_FFFF)
						: $urandom_range(65536, 32'h0080_0000);
					il[i] = recip_of(bl[i]);
				end
				BOX_TINY: begin
					bl[i] = $urandom_range(1, 65535);
					il[i] = recip_of(bl[i]);
				end
				default: begin
					bl[i] = $urandom;
					il[i] = $urandom;
				end
			endcase
		end
		if (kind == BOX_EXTREME) begin
			// top bit of the x length must be dropped
			bl = '{32'hFFFF_FFFF, 32'd65536, 32'd0};
			il = '{32'd0, 32'hFFFF_FFFF, $urandom};
		end
		set_reg(mivo_pkg::REG_BOX_X, bl[0]);
		set_reg(mivo_pkg::REG_BOX_Y, bl[1]);
		set_reg(mivo_pkg::REG_BOX_Z, bl[2]);
		set_reg(mivo_pkg::REG_INV_X, il[0]);
		set_reg(mivo_pkg::REG_INV_Y, il[1]);
		set_reg(mivo_pkg::REG_INV_Z, il[2]);
		// write past the last register; the block must ignore it
		cfg_idx   <= mivo_pkg::CFG_IDX_W'(mivo_pkg::REG_INV_Z + 1 + $urandom_range(1));
		cfg_wdata <= $urandom;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drop valid, wait for every result, then let the pipeline empty.
	task automatic settle();
		pair_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Hold the request until accepted; valid stays up for the next one.
	task automatic send_pair(input mivo_pkg::coord_t p[2*mivo_pkg::NAXES]);
		while ($urandom_range(99) < send_idle_pct) begin
			pair_valid <= 1'b0;
			@(negedge clk);
		end
		first_x    <= p[0];
		first_y    <= p[1];
		first_z    <= p[2];
		second_x   <= p[3];
		second_y   <= p[4];
		second_z   <= p[5];
		pair_valid <= 1'b1;
		@(posedge clk);
		while (pair_stall) @(posedge clk);
		@(negedge clk);
		pairs_sent++;
	endtask

	task automatic send_random_pair();
		mivo_pkg::coord_t p[2*mivo_pkg::NAXES];
		int               mode;
		longint           d;
		longint           span;
		mode = $urandom_range(99);
		for (int i = 0; i < mivo_pkg::NAXES; i++) begin
			span = longint'(lens[i]);
			if (mode < 35) begin
				p[i]                = $urandom;
				p[i+mivo_pkg::NAXES] = $urandom;
			end else if (mode < 75) begin
				// a few box lengths apart, often right on a rounding tie
				p[i] = mivo_pkg::coord_t'($urandom) >>> $urandom_range(24);
				d = longint'(int'($urandom_range(6)) - 3) * span;
				case ($urandom_range(2))
					0: d += span / 2;
					1: d -= span / 2;
					default: d += longint'($urandom_range(lens[i])) - span / 2;
				endcase
				p[i+mivo_pkg::NAXES] = mivo_pkg::coord_t'(longint'(p[i]) + d);
			end else if (mode < 90) begin
				p[i]                = pick_extreme();
				p[i+mivo_pkg::NAXES] = pick_extreme();
			end else begin
				p[i]                = $urandom;
				p[i+mivo_pkg::NAXES] = p[i] + mivo_pkg::coord_t'(int'($urandom_range(2)) - 1);
			end
		end
		send_pair(p);
	endtask

	initial begin
		mivo_pkg::coord_t p[2*mivo_pkg::NAXES];
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset box of 1.0: extremes, zero, half steps, equal points
		p = '{0, 0, 0, 0, 0, 0};
		send_pair(p);
		p = '{mivo_pkg::COORD_MIN, mivo_pkg::COORD_MIN, mivo_pkg::COORD_MIN,
			mivo_pkg::COORD_MIN, mivo_pkg::COORD_MIN, mivo_pkg::COORD_MIN};
		send_pair(p);
		p = '{mivo_pkg::COORD_MAX, mivo_pkg::COORD_MAX, mivo_pkg::COORD_MAX,
			mivo_pkg::COORD_MAX, mivo_pkg::COORD_MAX, mivo_pkg::COORD_MAX};
		send_pair(p);
		p = '{mivo_pkg::COORD_MAX, mivo_pkg::COORD_MAX, mivo_pkg::COORD_MAX,
			mivo_pkg::COORD_MIN, mivo_pkg::COORD_MIN, mivo_pkg::COORD_MIN};
		send_pair(p);
		p = '{mivo_pkg::COORD_MIN, mivo_pkg::COORD_MIN, mivo_pkg::COORD_MIN,
			mivo_pkg::COORD_MAX, mivo_pkg::COORD_MAX, mivo_pkg::COORD_MAX};
		send_pair(p);
		p = '{0, 0, 0, 32768, -32768, 98304};
		send_pair(p);
		p = '{123456, -98765, 7, 123456, -98765, 7};
		send_pair(p);

		// box 2.0 with an exact reciprocal: ties round away from zero
		settle();
		set_reg(mivo_pkg::REG_BOX_X, 32'd131072);
		set_reg(mivo_pkg::REG_BOX_Y, 32'd131072);
		set_reg(mivo_pkg::REG_BOX_Z, 32'd131072);
		set_reg(mivo_pkg::REG_INV_X, 32'h8000_0000);
		set_reg(mivo_pkg::REG_INV_Y, 32'h8000_0000);
		set_reg(mivo_pkg::REG_INV_Z, 32'h8000_0000);
		cfg_we <= 1'b0;
		p = '{0, 0, 0, 65536, -65536, 196608};
		send_pair(p);
		p = '{0, 0, 0, 65535, -65537, 196607};
		send_pair(p);
		p = '{100000, -100000, mivo_pkg::COORD_MIN, 165536, -165536,
			mivo_pkg::COORD_MIN + 196608};
		send_pair(p);

		// zero, sub-unit and full-range boxes, inconsistent reciprocals: saturation
		settle();
		set_reg(mivo_pkg::REG_BOX_X, 32'd0);
		set_reg(mivo_pkg::REG_BOX_Y, 32'd1);
		set_reg(mivo_pkg::REG_BOX_Z, 32'hFFFF_FFFF);
		set_reg(mivo_pkg::REG_INV_X, 32'hFFFF_FFFF);
		set_reg(mivo_pkg::REG_INV_Y, $urandom);
		set_reg(mivo_pkg::REG_INV_Z, 32'd0);
		cfg_we <= 1'b0;
		p = '{mivo_pkg::COORD_MIN, mivo_pkg::COORD_MIN, mivo_pkg::COORD_MIN,
			mivo_pkg::COORD_MAX, mivo_pkg::COORD_MAX, mivo_pkg::COORD_MAX};
		send_pair(p);
		p = '{mivo_pkg::COORD_MAX, mivo_pkg::COORD_MAX, mivo_pkg::COORD_MAX,
			mivo_pkg::COORD_MIN, mivo_pkg::COORD_MIN, mivo_pkg::COORD_MIN};
		send_pair(p);
		p = '{0, 0, 0, mivo_pkg::COORD_MAX, mivo_pkg::COORD_MIN, mivo_pkg::COORD_MAX};
		send_pair(p);
		repeat (3) send_random_pair();

		for (int s = 0; s < SEGMENTS; s++) begin
			settle();
			load_box(box_kind_t'(s % 4));
			send_idle_pct  = idle_send[(s + s / 4) % 4];
			recv_stall_pct = idle_recv[(s + s / 4) % 4];
			repeat (SEGMENT_ITEMS) send_random_pair();
		end

		settle();
		$display("summary: %0d pair requests checked after %0d register writes,", pairs_sent,
			reg_writes);
		$display("summary: fitted, extreme, raw and tiny boxes under four idle patterns");
		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
